// ===== hdl/msenv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msenv_pkg;

  localparam int unsigned SAMPLE_RATE     = 48000;
  localparam int unsigned NUM_PATCHES     = 7;
  localparam int unsigned MAX_SEGMENTS    = 3;
  localparam int unsigned SINE_TABLE_BITS = 10;

  localparam int unsigned QTR_BITS = SINE_TABLE_BITS - 2;
  localparam int unsigned QTR_LEN  = 1 << QTR_BITS;

  localparam logic [31:0]        DONE_THR    = 32'd1073742;
  localparam logic signed [31:0] REL_THR     = 32'sd107374;
  localparam logic [63:0]        HALFPI_Q30  = 64'd1686629713;
  localparam logic [15:0]        INTENS_BASE = 16'd21955;
  localparam logic [15:0]        INTENS_SPAN = 16'd10813;
  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [31:0] DIP_Q30     = -32'sd214748365;
  localparam logic signed [31:0] ZERO_Q30    = 32'sd0;

  localparam logic [63:0] SR64     = 64'(SAMPLE_RATE);
  localparam logic [31:0] TREM_INC = 32'(((64'd6 << 32) + 64'(SAMPLE_RATE / 2)) / SR64);

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_HOLD = 2'd2,
    PH_REL  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_STEP,
    SQ_APPLY,
    SQ_SCALE,
    SQ_OUT
  } seq_e;

  typedef struct packed {
    logic signed [31:0] target;
    logic [29:0]        coeff;
    logic               hold;
  } seg_t;

  typedef struct packed {
    logic        sign_neg;
    logic [2:0]  nseg;
    logic [29:0] rel_coeff;
    logic        trem;
  } patch_t;

  typedef logic [QTR_LEN-1:0][30:0] sine_rom_t;
  typedef logic [127:0][15:0]       intens_rom_t;

  // exp(-6.908 / n) in Q0.30 from x = 6.908 / n in Q30, series up to the tenth power
  function automatic logic [29:0] rc_coeff(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 30;
    sum  = term;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x) >> 30) / 64'(k);
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum[29:0];
  endfunction

  localparam logic [63:0] X_2    = (64'd6908 << 30) / (64'd2 * SR64);
  localparam logic [63:0] X_16   = (64'd6908 << 30) / (64'd16 * SR64);
  localparam logic [63:0] X_32   = (64'd6908 << 30) / (64'd32 * SR64);
  localparam logic [63:0] X_50   = (64'd6908 << 30) / (64'd50 * SR64);
  localparam logic [63:0] X_128  = (64'd6908 << 30) / (64'd128 * SR64);
  localparam logic [63:0] X_512  = (64'd6908 << 30) / (64'd512 * SR64);
  localparam logic [63:0] X_1000 = (64'd6908 << 30) / (64'd1000 * SR64);
  localparam logic [63:0] X_2000 = (64'd6908 << 30) / (64'd2000 * SR64);
  localparam logic [63:0] X_2048 = (64'd6908 << 30) / (64'd2048 * SR64);
  localparam logic [63:0] X_3000 = (64'd6908 << 30) / (64'd3000 * SR64);

  localparam logic [29:0] C_2    = rc_coeff(X_2);
  localparam logic [29:0] C_16   = rc_coeff(X_16);
  localparam logic [29:0] C_32   = rc_coeff(X_32);
  localparam logic [29:0] C_50   = rc_coeff(X_50);
  localparam logic [29:0] C_128  = rc_coeff(X_128);
  localparam logic [29:0] C_512  = rc_coeff(X_512);
  localparam logic [29:0] C_1000 = rc_coeff(X_1000);
  localparam logic [29:0] C_2000 = rc_coeff(X_2000);
  localparam logic [29:0] C_2048 = rc_coeff(X_2048);
  localparam logic [29:0] C_3000 = rc_coeff(X_3000);
  localparam logic [29:0] C_NONE = 30'd0;

  // first-quadrant sine in Q30, clamped to [0, 1]
  function automatic logic [30:0] quarter_sine(input int unsigned j);
    logic [63:0] a;
    logic [63:0] term;
    longint      sum;
    a    = (64'(j) * HALFPI_Q30) >> QTR_BITS;
    term = a;
    sum  = longint'(a);
    for (int k = 1; k <= 7; k++) begin
      term = ((((term * a) >> 30) * a) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    return sum[30:0];
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t r;
    for (int j = 0; j < QTR_LEN; j++) begin
      r[j] = quarter_sine(j);
    end
    return r;
  endfunction

  localparam sine_rom_t   SINE_ROM  = build_sine();
  localparam logic [30:0] SINE_PEAK = quarter_sine(QTR_LEN);

  function automatic logic [15:0] intens_of(input int unsigned vel);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = (64'(vel) << 30) / 64'd127;
    r = 64'd0;
    for (int i = 15; i >= 0; i--) begin
      b = 64'd1 << i;
      if ((r + b) * (r + b) <= n) begin
        r = r + b;
      end
    end
    return 16'(64'(INTENS_BASE) + ((r * 64'(INTENS_SPAN)) >> 15));
  endfunction

  function automatic intens_rom_t build_intens();
    intens_rom_t r;
    for (int v = 0; v < 128; v++) begin
      r[v] = intens_of(v);
    end
    return r;
  endfunction

  localparam intens_rom_t INTENS_ROM = build_intens();

  function automatic patch_t patch_info(input logic [2:0] p);
    patch_t r;
    r = '0;
    unique case (p)
      3'd0: r = '{sign_neg: 1'b0, nseg: 3'd1, rel_coeff: C_1000, trem: 1'b0};
      3'd1: r = '{sign_neg: 1'b1, nseg: 3'd1, rel_coeff: C_1000, trem: 1'b0};
      3'd2: r = '{sign_neg: 1'b0, nseg: 3'd3, rel_coeff: C_NONE, trem: 1'b0};
      3'd3: r = '{sign_neg: 1'b0, nseg: 3'd2, rel_coeff: C_NONE, trem: 1'b0};
      3'd4: r = '{sign_neg: 1'b0, nseg: 3'd2, rel_coeff: C_NONE, trem: 1'b0};
      3'd5: r = '{sign_neg: 1'b0, nseg: 3'd2, rel_coeff: C_NONE, trem: 1'b0};
      3'd6: r = '{sign_neg: 1'b0, nseg: 3'd1, rel_coeff: C_50, trem: 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic seg_t seg_info(input logic [2:0] p, input logic [1:0] s);
    seg_t r;
    r = '0;
    unique case ({p, s})
      {3'd0, 2'd0}: r = '{target: ONE_Q30, coeff: C_2000, hold: 1'b1};
      {3'd1, 2'd0}: r = '{target: ONE_Q30, coeff: C_3000, hold: 1'b1};
      {3'd2, 2'd0}: r = '{target: ONE_Q30, coeff: C_32, hold: 1'b0};
      {3'd2, 2'd1}: r = '{target: DIP_Q30, coeff: C_512, hold: 1'b0};
      {3'd2, 2'd2}: r = '{target: ZERO_Q30, coeff: C_2048, hold: 1'b0};
      {3'd3, 2'd0}: r = '{target: ONE_Q30, coeff: C_1000, hold: 1'b0};
      {3'd3, 2'd1}: r = '{target: ZERO_Q30, coeff: C_1000, hold: 1'b0};
      {3'd4, 2'd0}: r = '{target: ONE_Q30, coeff: C_2, hold: 1'b0};
      {3'd4, 2'd1}: r = '{target: ZERO_Q30, coeff: C_512, hold: 1'b0};
      {3'd5, 2'd0}: r = '{target: ONE_Q30, coeff: C_16, hold: 1'b0};
      {3'd5, 2'd1}: r = '{target: ZERO_Q30, coeff: C_128, hold: 1'b0};
      {3'd6, 2'd0}: r = '{target: ZERO_Q30, coeff: C_NONE, hold: 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/msenv_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface msenv_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [2:0] patch;
  logic [6:0] velocity;

  modport source (output valid, output operation, output patch, output velocity, input ready);
  modport sink (input valid, input operation, input patch, input velocity, output ready);
endinterface

`default_nettype wire

// ===== hdl/msenv_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface msenv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] octaves;
  logic               active;

  modport source (output valid, output octaves, output active, input ready);
  modport sink (input valid, input octaves, input active, output ready);
endinterface

`default_nettype wire

// ===== hdl/multi_segment_envelope_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Envelope generator for filter modulation. Input words are note on, note off
// or sample tick; each tick returns one output word (octaves in signed Q4.12
// plus an active flag), note on and note off return nothing and keep input
// ready. A tick keeps the input side busy from acceptance until its word is
// loaded into the output register, via STEP, APPLY, SCALE and OUT (APPLY is
// skipped when idle, past the last segment or holding without tremolo): one
// 32x30 multiplier is shared by the level update and the intensity scaling,
// and a small sequencer steps through them one after the other. The output
// register lets the next word in while a finished word still waits to be taken.
module multi_segment_envelope_generator (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  msenv_in_if.sink             in_i,
  msenv_out_if.source          out_o
);

  msenv_pkg::seq_e   seq_q, seq_d;
  msenv_pkg::phase_e phase_q, phase_d;

  logic signed [31:0] level_q, level_d;
  logic [1:0]         seg_q, seg_d;
  logic [2:0]         patch_q, patch_d;
  logic [15:0]        intens_q, intens_d;
  logic [31:0]        trem_q, trem_d;
  logic [61:0]        prod_q;
  logic               neg_q, neg_d;
  logic               prod_en;

  logic               out_valid_q, out_valid_d;
  logic signed [15:0] octaves_q, octaves_d;
  logic               active_q, active_d;

  logic [31:0] mul_a;
  logic [29:0] mul_b;
  logic [61:0] mul_p;

  msenv_pkg::patch_t pinfo;
  msenv_pkg::seg_t   sinfo;

  logic        in_ready;
  logic        in_acc;
  logic        out_load;
  logic        seg_over;
  logic signed [32:0] diff;
  logic [31:0] diff_mag;
  logic [31:0] level_mag;
  logic [31:0] step_mag;
  logic signed [32:0] step_sgn;
  logic [32:0] run_sum;
  logic        done;
  logic [2:0]  seg_inc;

  logic [msenv_pkg::SINE_TABLE_BITS-1:0] tidx;
  logic [1:0]                            quad;
  logic [msenv_pkg::QTR_BITS-1:0]        tj, tj_mir;
  logic [30:0]                           sine_val;
  logic [29:0]                           half;
  logic signed [31:0]                    trem_lv;

  logic [49:0] scaled;
  logic [16:0] mag;
  logic signed [15:0] oct_val;

  assign in_ready   = (seq_q == msenv_pkg::SQ_IDLE);
  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid & in_ready;
  assign out_load   = (seq_q == msenv_pkg::SQ_OUT) & (~out_valid_q | out_o.ready);

  assign out_o.valid   = out_valid_q;
  assign out_o.octaves = octaves_q;
  assign out_o.active  = active_q;

  assign pinfo = msenv_pkg::patch_info(patch_q);
  assign sinfo = msenv_pkg::seg_info(patch_q, seg_q);

  assign mul_p = mul_a * mul_b;

  assign seg_over = ({1'b0, seg_q} >= pinfo.nseg) ||
                    (32'(seg_q) >= msenv_pkg::MAX_SEGMENTS);
  assign diff      = {level_q[31], level_q} - {sinfo.target[31], sinfo.target};
  assign diff_mag  = diff[32] ? 32'(-diff) : diff[31:0];
  assign level_mag = level_q[31] ? 32'(-level_q) : 32'(level_q);

  assign step_mag = prod_q[61:30];
  assign step_sgn = neg_q ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
  assign run_sum  = 33'({sinfo.target[31], sinfo.target} + step_sgn);
  assign done     = step_mag < msenv_pkg::DONE_THR;
  assign seg_inc  = {1'b0, seg_q} + 3'd1;

  // tremolo: quarter-wave table with mirrored second and fourth quadrants
  assign tidx   = trem_q[31 -: msenv_pkg::SINE_TABLE_BITS];
  assign quad   = tidx[msenv_pkg::SINE_TABLE_BITS-1 -: 2];
  assign tj     = tidx[msenv_pkg::QTR_BITS-1:0];
  assign tj_mir = -tj;
  always_comb begin
    if (quad[0] && (tj == '0)) begin
      sine_val = msenv_pkg::SINE_PEAK;
    end else if (quad[0]) begin
      sine_val = msenv_pkg::SINE_ROM[tj_mir];
    end else begin
      sine_val = msenv_pkg::SINE_ROM[tj];
    end
  end
  assign half    = sine_val[30:1];
  assign trem_lv = quad[1] ? -$signed({2'b00, half}) : $signed({2'b00, half});

  // x5, drop 33 fraction bits, saturate to Q4.12
  assign scaled = {2'b00, prod_q[46:0], 1'b0} + {3'b000, prod_q[46:0]} +
                  {1'b0, prod_q[46:0], 2'b00} - {2'b00, prod_q[46:0], 1'b0};
  assign mag    = scaled[49:33];
  always_comb begin
    if (neg_q) begin
      oct_val = (mag > 17'd32768) ? 16'sh8000 : 16'(-mag);
    end else begin
      oct_val = (mag > 17'd32767) ? 16'sh7fff : 16'(mag);
    end
  end

  // sequencer next state
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      msenv_pkg::SQ_IDLE: begin
        if (in_acc && (in_i.operation == msenv_pkg::OP_TICK)) begin
          seq_d = msenv_pkg::SQ_STEP;
        end
      end
      msenv_pkg::SQ_STEP: begin
        unique case (phase_q)
          msenv_pkg::PH_RUN:  seq_d = seg_over ? msenv_pkg::SQ_SCALE : msenv_pkg::SQ_APPLY;
          msenv_pkg::PH_REL:  seq_d = msenv_pkg::SQ_APPLY;
          msenv_pkg::PH_HOLD: seq_d = pinfo.trem ? msenv_pkg::SQ_APPLY : msenv_pkg::SQ_SCALE;
          default:            seq_d = msenv_pkg::SQ_SCALE;
        endcase
      end
      msenv_pkg::SQ_APPLY: seq_d = msenv_pkg::SQ_SCALE;
      msenv_pkg::SQ_SCALE: seq_d = msenv_pkg::SQ_OUT;
      msenv_pkg::SQ_OUT: begin
        if (out_load) begin
          seq_d = msenv_pkg::SQ_IDLE;
        end
      end
      default: seq_d = msenv_pkg::SQ_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    phase_d     = phase_q;
    level_d     = level_q;
    seg_d       = seg_q;
    patch_d     = patch_q;
    intens_d    = intens_q;
    trem_d      = trem_q;
    neg_d       = neg_q;
    prod_en     = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    out_valid_d = out_valid_q & ~out_o.ready;
    octaves_d   = octaves_q;
    active_d    = active_q;

    unique case (seq_q)
      msenv_pkg::SQ_IDLE: begin
        if (in_acc) begin
          unique case (in_i.operation)
            msenv_pkg::OP_NOTE_ON: begin
              if ({1'b0, in_i.patch} < 4'(msenv_pkg::NUM_PATCHES)) begin
                patch_d  = in_i.patch;
                intens_d = msenv_pkg::INTENS_ROM[in_i.velocity];
                trem_d   = '0;
                level_d  = '0;
                seg_d    = '0;
                phase_d  = msenv_pkg::PH_RUN;
              end
            end
            msenv_pkg::OP_NOTE_OFF: begin
              if ((phase_q == msenv_pkg::PH_RUN) || (phase_q == msenv_pkg::PH_HOLD)) begin
                phase_d = msenv_pkg::PH_REL;
              end
            end
            default: ;
          endcase
        end
      end
      msenv_pkg::SQ_STEP: begin
        unique case (phase_q)
          msenv_pkg::PH_RUN: begin
            if (seg_over) begin
              level_d = '0;
              phase_d = msenv_pkg::PH_IDLE;
            end else begin
              mul_a   = diff_mag;
              mul_b   = sinfo.coeff;
              neg_d   = diff[32];
              prod_en = 1'b1;
            end
          end
          msenv_pkg::PH_REL: begin
            mul_a   = level_mag;
            mul_b   = pinfo.rel_coeff;
            neg_d   = level_q[31];
            prod_en = 1'b1;
          end
          msenv_pkg::PH_HOLD: begin
            if (pinfo.trem) begin
              trem_d = trem_q + msenv_pkg::TREM_INC;
            end
          end
          default: ;
        endcase
      end
      msenv_pkg::SQ_APPLY: begin
        unique case (phase_q)
          msenv_pkg::PH_RUN: begin
            if (done) begin
              level_d = sinfo.target;
              if (sinfo.hold) begin
                phase_d = msenv_pkg::PH_HOLD;
              end else if (seg_inc < pinfo.nseg) begin
                seg_d = seg_q + 2'd1;
              end else begin
                level_d = '0;
                phase_d = msenv_pkg::PH_IDLE;
              end
            end else begin
              level_d = $signed(run_sum[31:0]);
            end
          end
          msenv_pkg::PH_REL: begin
            if ($signed(step_sgn[31:0]) < msenv_pkg::REL_THR) begin
              level_d = '0;
              phase_d = msenv_pkg::PH_IDLE;
            end else begin
              level_d = $signed(step_sgn[31:0]);
            end
          end
          msenv_pkg::PH_HOLD: level_d = trem_lv;
          default: ;
        endcase
      end
      msenv_pkg::SQ_SCALE: begin
        mul_a   = level_mag;
        mul_b   = 30'(intens_q);
        neg_d   = level_q[31] ^ pinfo.sign_neg;
        prod_en = 1'b1;
      end
      msenv_pkg::SQ_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          octaves_d   = oct_val;
          active_d    = (phase_q != msenv_pkg::PH_IDLE);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= msenv_pkg::SQ_IDLE;
      phase_q     <= msenv_pkg::PH_IDLE;
      level_q     <= '0;
      seg_q       <= '0;
      patch_q     <= '0;
      intens_q    <= '0;
      trem_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      phase_q     <= phase_d;
      level_q     <= level_d;
      seg_q       <= seg_d;
      patch_q     <= patch_d;
      intens_q    <= intens_d;
      trem_q      <= trem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en) begin
      prod_q <= mul_p;
    end
    neg_q     <= neg_d;
    octaves_q <= octaves_d;
    active_q  <= active_d;
  end

endmodule

`default_nettype wire

// ===== hdl/msenv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msenv_checker (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              in_valid_i,
  input wire              in_ready_i,
  input wire [1:0]        operation_i,
  input wire              out_valid_i,
  input wire              out_ready_i,
  input wire signed [15:0] octaves_i,
  input wire              active_i
);

  logic tick_acc;
  assign tick_acc = in_valid_i && in_ready_i && (operation_i == msenv_pkg::OP_TICK);

  // stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(octaves_i) && $stable(active_i))
    else $error("output word changed while stalled");

  // an idle envelope gives no modulation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !active_i |-> octaves_i == 16'sd0)
    else $error("nonzero octaves while inactive");

  // a tick keeps the input side busy while it is computed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> !in_ready_i)
    else $error("input ready right after a tick");

  // a tick result goes through the sequencer before it reaches the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc && !out_valid_i |=> !out_valid_i ##1 !out_valid_i)
    else $error("output word appeared too early");

endmodule

bind multi_segment_envelope_generator msenv_checker u_msenv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .operation_i (in_i.operation),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .octaves_i   (out_o.octaves),
  .active_i    (out_o.active)
);

`default_nettype wire

// ===== sim/multi_segment_envelope_generator_test.sv =====
`timescale 1ns / 1ps

module multi_segment_envelope_generator_test;
  import msenv_pkg::*;

  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int unsigned RUN_ITEMS  = 1050;
  localparam int unsigned MAX_CYCLES = 200000;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned DRAIN_LEN  = 20;
  localparam int unsigned QTR        = 1 << (SINE_TABLE_BITS - 2);
  localparam longint      DONE_DIST  = 1073742;
  localparam int          REL_FLOOR  = 107374;
  localparam logic [31:0] TREM_STEP  =
    32'(((64'd6 << 32) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));

  typedef struct {
    logic [1:0] op;
    logic [2:0] patch;
    logic [6:0] vel;
  } env_event_t;

  typedef struct {
    logic signed [15:0] octaves;
    logic               active;
  } mod_word_t;

  typedef struct {
    int          sign;
    int unsigned nseg;
    int unsigned rel_ms;
    bit          trem;
  } voice_t;

  typedef struct {
    int          target;
    int unsigned ms;
    bit          hold;
  } stage_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  msenv_in_if  env_in ();
  msenv_out_if env_out ();

  multi_segment_envelope_generator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (env_in),
    .out_o  (env_out)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  env_event_t  note_events[$];
  mod_word_t   octave_forecast[$];
  int unsigned live_items = 0;
  int unsigned total_words = 0;
  int unsigned sent_count = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic        hold_off;
  logic        hold_used;
  int unsigned hold_cycles;

  // envelope state as the block should hold it
  phase_e             ph = PH_IDLE;
  logic signed [31:0] lvl = '0;
  logic [1:0]         seg_idx = '0;
  logic [2:0]         slot = '0;
  logic [15:0]        intens = '0;
  logic [31:0]        tphase = '0;

  function automatic voice_t voice_desc(input logic [2:0] s);
    voice_t v;
    v = '{sign: 1, nseg: 1, rel_ms: 0, trem: 1'b0};
    case (s)
      3'd0: v = '{sign: 1, nseg: 1, rel_ms: 1000, trem: 1'b0};
      3'd1: v = '{sign: -1, nseg: 1, rel_ms: 1000, trem: 1'b0};
      3'd2: v = '{sign: 1, nseg: 3, rel_ms: 0, trem: 1'b0};
      3'd3: v = '{sign: 1, nseg: 2, rel_ms: 0, trem: 1'b0};
      3'd4: v = '{sign: 1, nseg: 2, rel_ms: 0, trem: 1'b0};
      3'd5: v = '{sign: 1, nseg: 2, rel_ms: 0, trem: 1'b0};
      3'd6: v = '{sign: 1, nseg: 1, rel_ms: 50, trem: 1'b1};
      default: v = '{sign: 1, nseg: 1, rel_ms: 1000, trem: 1'b0};
    endcase
    return v;
  endfunction

  function automatic stage_t stage_desc(input logic [2:0] s, input logic [1:0] i);
    stage_t g;
    g = '{target: 0, ms: 0, hold: 1'b0};
    case ({s, i})
      {3'd0, 2'd0}: g = '{target: 1073741824, ms: 2000, hold: 1'b1};
      {3'd1, 2'd0}: g = '{target: 1073741824, ms: 3000, hold: 1'b1};
      {3'd2, 2'd0}: g = '{target: 1073741824, ms: 32, hold: 1'b0};
      {3'd2, 2'd1}: g = '{target: -214748365, ms: 512, hold: 1'b0};
      {3'd2, 2'd2}: g = '{target: 0, ms: 2048, hold: 1'b0};
      {3'd3, 2'd0}: g = '{target: 1073741824, ms: 1000, hold: 1'b0};
      {3'd3, 2'd1}: g = '{target: 0, ms: 1000, hold: 1'b0};
      {3'd4, 2'd0}: g = '{target: 1073741824, ms: 2, hold: 1'b0};
      {3'd4, 2'd1}: g = '{target: 0, ms: 512, hold: 1'b0};
      {3'd5, 2'd0}: g = '{target: 1073741824, ms: 16, hold: 1'b0};
      {3'd5, 2'd1}: g = '{target: 0, ms: 128, hold: 1'b0};
      {3'd6, 2'd0}: g = '{target: 0, ms: 1, hold: 1'b1};
      default: g = '{target: 0, ms: 0, hold: 1'b0};
    endcase
    return g;
  endfunction

  // per-sample RC coefficient in Q0.30, zero for times of 1 ms or less
  function automatic longint decay_coeff(input int unsigned ms);
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    if (ms <= 1) return 0;
    x    = (64'd6908 << 30) / (64'(ms) * 64'(SAMPLE_RATE));
    term = 64'd1 << 30;
    acc  = longint'(term);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x) >> 30) / 64'(k);
      if ((k % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return acc;
  endfunction

  function automatic longint q30_scale(input longint a, input longint c);
    longint unsigned m;
    longint unsigned prd;
    m   = (a < 0) ? -a : a;
    prd = (m * c) >> 30;
    return (a < 0) ? -longint'(prd) : longint'(prd);
  endfunction

  function automatic logic [15:0] vel_gain(input logic [6:0] v);
    longint unsigned n;
    longint unsigned r;
    longint unsigned b;
    n = (64'(v) << 30) / 64'd127;
    r = 0;
    for (int i = 15; i >= 0; i--) begin
      b = 64'd1 << i;
      if ((r + b) * (r + b) <= n) r = r + b;
    end
    return 16'(64'd21955 + ((r * 64'd10813) >> 15));
  endfunction

  function automatic longint unsigned sine_quadrant(input int unsigned j);
    longint unsigned a;
    longint unsigned term;
    longint          acc;
    a    = (64'(j) * 64'd1686629713) >> (SINE_TABLE_BITS - 2);
    term = a;
    acc  = longint'(a);
    for (int k = 1; k <= 7; k++) begin
      term = ((((term * a) >> 30) * a) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > 1073741824) acc = 1073741824;
    return longint'(acc);
  endfunction

  function automatic logic signed [31:0] trem_value();
    int unsigned        idx;
    int unsigned        quad;
    int unsigned        j;
    logic signed [31:0] half;
    idx  = tphase >> (32 - SINE_TABLE_BITS);
    quad = idx >> (SINE_TABLE_BITS - 2);
    j    = idx & (QTR - 1);
    if (quad[0]) j = QTR - j;
    half = 32'(sine_quadrant(j) >> 1);
    return quad[1] ? -half : half;
  endfunction

  function automatic void advance_segment(input voice_t vd);
    stage_t sd;
    longint tgt;
    longint nl;
    longint gap;
    bit     instant;
    if (seg_idx >= vd.nseg || seg_idx >= MAX_SEGMENTS) begin
      lvl = '0;
      ph  = PH_IDLE;
      return;
    end
    sd      = stage_desc(slot, seg_idx);
    tgt     = sd.target;
    instant = (sd.ms <= 1);
    if (instant) begin
      nl = tgt;
    end else begin
      nl = tgt + q30_scale(longint'(lvl) - tgt, decay_coeff(sd.ms));
    end
    gap = (nl < tgt) ? tgt - nl : nl - tgt;
    lvl = nl[31:0];
    if (instant || gap < DONE_DIST) begin
      lvl = tgt[31:0];
      if (sd.hold) begin
        ph = PH_HOLD;
      end else if (seg_idx + 1 < vd.nseg) begin
        seg_idx = seg_idx + 2'd1;
      end else begin
        lvl = '0;
        ph  = PH_IDLE;
      end
    end
  endfunction

  // returns 1 when the word yields an output word
  function automatic bit envelope_step(input env_event_t ev, output mod_word_t res);
    voice_t          vd;
    longint          c;
    longint          prod;
    longint unsigned mag;
    longint          val;
    res = '{octaves: '0, active: 1'b0};
    case (ev.op)
      OP_NOTE_ON: begin
        if (ev.patch >= NUM_PATCHES) return 1'b0;
        slot    = ev.patch;
        intens  = vel_gain(ev.vel);
        tphase  = '0;
        lvl     = '0;
        seg_idx = '0;
        ph      = PH_RUN;
        return 1'b0;
      end
      OP_NOTE_OFF: begin
        if (ph == PH_RUN || ph == PH_HOLD) ph = PH_REL;
        return 1'b0;
      end
      OP_TICK: ;
      default: return 1'b0;
    endcase
    if (ph == PH_IDLE) return 1'b1;
    vd = voice_desc(slot);
    if (ph == PH_HOLD) begin
      if (vd.trem) begin
        tphase = tphase + TREM_STEP;
        lvl    = trem_value();
      end
    end else if (ph == PH_REL) begin
      c = decay_coeff(vd.rel_ms);
      if (c > 0) begin
        lvl = 32'(q30_scale(longint'(lvl), c));
      end else begin
        lvl = '0;
      end
      if (lvl < REL_FLOOR) begin
        lvl = '0;
        ph  = PH_IDLE;
      end
    end else begin
      advance_segment(vd);
    end
    prod = longint'(lvl) * longint'(intens) * 5 * longint'(vd.sign);
    mag  = ((prod < 0) ? -prod : prod);
    mag  = mag >> 33;
    val  = (prod < 0) ? -longint'(mag) : longint'(mag);
    if (val > 32767) val = 32767;
    if (val < -32768) val = -32768;
    res.octaves = val[15:0];
    res.active  = (ph != PH_IDLE);
    return 1'b1;
  endfunction

  task automatic add_event(input logic [1:0] op, input logic [2:0] pt, input logic [6:0] v);
    env_event_t e;
    e.op    = op;
    e.patch = pt;
    e.vel   = v;
    note_events.push_back(e);
    if (op != OP_UNUSED && !(op == OP_NOTE_ON && pt >= NUM_PATCHES)) live_items++;
  endtask

  task automatic add_ticks(input int unsigned n);
    repeat (n) add_event(OP_TICK, 3'($urandom_range(7)), 7'($urandom_range(127)));
  endtask

  // driver
  env_event_t drv_cur;
  env_event_t drv_next;
  mod_word_t  drv_res;
  wire        tx_quiet = (sent_count >= 500) && (sent_count < 800);

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_in.valid     <= 1'b0;
      env_in.operation <= OP_TICK;
      env_in.patch     <= '0;
      env_in.velocity  <= '0;
    end else begin
      if (env_in.valid && env_in.ready) begin
        drv_cur.op    = env_in.operation;
        drv_cur.patch = env_in.patch;
        drv_cur.vel   = env_in.velocity;
        if (envelope_step(drv_cur, drv_res)) octave_forecast.push_back(drv_res);
        sent_count <= sent_count + 1;
      end
      if (!env_in.valid || env_in.ready) begin
        if (note_events.size() != 0 && (tx_quiet || $urandom_range(99) >= 9)) begin
          drv_next = note_events.pop_front();
          env_in.valid     <= 1'b1;
          env_in.operation <= drv_next.op;
          env_in.patch     <= drv_next.patch;
          env_in.velocity  <= drv_next.vel;
        end else begin
          env_in.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  mod_word_t mon_want;
  wire       rx_quiet = (results_seen >= 450) && (results_seen < 750);

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_out.ready <= 1'b0;
    end else begin
      if (env_out.valid && env_out.ready) begin
        if (octave_forecast.size() == 0) begin
          $display("%0t: unexpected word octaves %0d active %0d", $time,
                   env_out.octaves, env_out.active);
          mismatches++;
        end else begin
          mon_want = octave_forecast.pop_front();
          if (env_out.octaves !== mon_want.octaves) begin
            $display("%0t: octaves expected %0d got %0d", $time, mon_want.octaves,
                     env_out.octaves);
            mismatches++;
          end
          if (env_out.active !== mon_want.active) begin
            $display("%0t: active expected %0d got %0d", $time, mon_want.active,
                     env_out.active);
            mismatches++;
          end
        end
        results_seen <= results_seen + 1;
      end
      env_out.ready <= !(hold_off || (!rx_quiet && $urandom_range(99) < 9));
    end
  end

  // one long output stall so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off    <= 1'b0;
      hold_used   <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_off) begin
      if (hold_cycles == HOLD_LEN - 1) hold_off <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else if (!hold_used && results_seen >= 200) begin
      hold_off  <= 1'b1;
      hold_used <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("multi_segment_envelope_generator_test NOT OK");
      $finish;
    end
  end

  initial begin
    bit         long_run;
    logic [2:0] slot_pick;
    logic [6:0] vel_pick;

    rst_ni <= 1'b0;

    // idle tick, stray note off, unused op, bad patch
    add_event(OP_TICK, 3'd0, 7'd0);
    add_event(OP_NOTE_OFF, 3'd0, 7'd0);
    add_event(OP_UNUSED, 3'd7, 7'd127);
    add_event(OP_NOTE_ON, 3'd7, 7'd127);
    add_event(OP_TICK, 3'd7, 7'd127);
    add_event(OP_NOTE_ON, 3'd0, 7'd0);
    add_event(OP_TICK, 3'd0, 7'd0);
    // inverted patch, release, note off while releasing
    add_event(OP_NOTE_ON, 3'd1, 7'd127);
    add_event(OP_TICK, 3'd0, 7'd0);
    add_event(OP_NOTE_OFF, 3'd0, 7'd0);
    add_event(OP_TICK, 3'd0, 7'd0);
    add_event(OP_NOTE_OFF, 3'd0, 7'd0);
    add_event(OP_TICK, 3'd0, 7'd0);
    // instant segment into tremolo hold
    add_event(OP_NOTE_ON, 3'd6, 7'd127);
    add_event(OP_TICK, 3'd0, 7'd0);
    add_event(OP_TICK, 3'd0, 7'd0);
    add_event(OP_NOTE_OFF, 3'd0, 7'd0);
    add_event(OP_TICK, 3'd0, 7'd0);
    // no release time: next tick goes idle
    add_event(OP_NOTE_ON, 3'd2, 7'd64);
    add_event(OP_TICK, 3'd0, 7'd0);
    add_event(OP_NOTE_OFF, 3'd0, 7'd0);
    add_event(OP_TICK, 3'd0, 7'd0);
    add_event(OP_NOTE_ON, 3'd4, 7'd1);
    add_event(OP_TICK, 3'd0, 7'd0);
    add_event(OP_NOTE_ON, 3'd5, 7'd85);
    add_event(OP_TICK, 3'd0, 7'd0);

    live_items = 0;
    while (live_items < RUN_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        long_run  = ($urandom_range(99) < 20);
        slot_pick = (long_run && $urandom_range(1) == 1) ? 3'd4 : 3'($urandom_range(6));
        case ($urandom_range(9))
          0: vel_pick = 7'd0;
          1: vel_pick = 7'd127;
          default: vel_pick = 7'($urandom_range(127));
        endcase
        add_event(OP_NOTE_ON, slot_pick, vel_pick);
        add_ticks(long_run ? $urandom_range(90, 160) : $urandom_range(1, 40));
        if ($urandom_range(99) < 60) begin
          add_event(OP_NOTE_OFF, 3'($urandom_range(7)), 7'($urandom_range(127)));
          add_ticks($urandom_range(1, 20));
        end
      end else begin
        repeat ($urandom_range(1, 5))
          add_event(2'($urandom_range(3)), 3'($urandom_range(7)), 7'($urandom_range(127)));
      end
    end
    total_words = note_events.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_count < total_words) @(posedge clk_i);
    while (octave_forecast.size() != 0) @(posedge clk_i);
    repeat (DRAIN_LEN) @(posedge clk_i);

    if (octave_forecast.size() != 0) begin
      $display("%0t: %0d words never arrived", $time, octave_forecast.size());
    end
    if (mismatches == 0 && octave_forecast.size() == 0) begin
      $display("multi_segment_envelope_generator_test OK");
    end else begin
      $display("multi_segment_envelope_generator_test NOT OK");
    end
    $finish;
  end

endmodule
